### sv/rell_pkg.sv
package rell_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COUNT_W  = $clog2(MAX_COLS + 1);

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int THR_W    = 8;
    localparam int DIFF_W   = PIX_W + 1;
    localparam int OFF_W    = COL_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WATCH_ROW      = 2'd0,
        REG_CENTER_COLUMN  = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } rell_reg_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] rise_col;
        logic [COL_W-1:0] fall_col;
        logic             all_nonzero;
    } rell_event_t;

endpackage

### sv/row_edge_line_locator.sv
// channel   handshake              payload
// input     in_valid / in_stall    pixel, row_index, row_end
// output    out_valid / out_stall  line_offset, line_width, line_found, row_all_nonzero
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle while in_stall is low; edge tracking is updated in the cycle of the transfer.
// After the last pixel of the watched row, the result goes to the event register, then the output register.
// One result waits in an event register, one in the output register.
// in_stall rises only while both are full and out_stall is high.
// Reset clears the row state, the config registers and both valid flags.
module row_edge_line_locator
    import rell_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PIX_W-1:0]        pixel,
    input  logic [ROW_W-1:0]        row_index,
    input  logic                    row_end,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OFF_W-1:0] line_offset,
    output logic [COL_W-1:0]        line_width,
    output logic                    line_found,
    output logic                    row_all_nonzero,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data
);

    logic [ROW_W-1:0] watch_row_reg;
    logic [COL_W-1:0] center_column_reg;
    logic [THR_W-1:0] edge_threshold_reg;
    logic             accept;
    logic             take;
    rell_event_t      event_q;

    assign cfg_ready = 1'b1;
    assign in_stall  = event_q.valid && !take;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_row_reg      <= '0;
            center_column_reg  <= '0;
            edge_threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rell_reg_t'(cfg_index))
                REG_WATCH_ROW:      watch_row_reg      <= cfg_data[ROW_W-1:0];
                REG_CENTER_COLUMN:  center_column_reg  <= cfg_data[COL_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    rell_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .pixel          (pixel),
        .row_index      (row_index),
        .row_end        (row_end),
        .watch_row      (watch_row_reg),
        .edge_threshold (edge_threshold_reg),
        .take           (take),
        .event_q        (event_q)
    );

    rell_result u_result (
        .clk             (clk),
        .rst_n           (rst_n),
        .event_q         (event_q),
        .center_column   (center_column_reg),
        .take            (take),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_offset     (line_offset),
        .line_width      (line_width),
        .line_found      (line_found),
        .row_all_nonzero (row_all_nonzero)
    );

endmodule

### sv/rell_scan.sv
module rell_scan
    import rell_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    input  logic [ROW_W-1:0] row_index,
    input  logic             row_end,
    input  logic [ROW_W-1:0] watch_row,
    input  logic [THR_W-1:0] edge_threshold,
    input  logic             take,
    output rell_event_t      event_q
);

    logic [PIX_W-1:0]         prev_reg;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic signed [DIFF_W-1:0] rise_val_reg, rise_val_next;
    logic signed [DIFF_W-1:0] fall_val_reg, fall_val_next;
    logic [COL_W-1:0]         rise_col_reg, rise_col_next;
    logic [COL_W-1:0]         fall_col_reg, fall_col_next;
    logic                     nz_reg, nz_next;
    rell_event_t              event_reg, event_next;

    logic                     watched;
    logic                     in_range;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] thr;
    logic signed [DIFF_W-1:0] neg_thr;
    logic [COUNT_W-1:0]       col_m1;

    assign watched  = (row_index == watch_row) && (int'(watch_row) < MAX_ROWS);
    assign in_range = int'(count_reg) < MAX_COLS;
    assign diff     = $signed({1'b0, prev_reg}) - $signed({1'b0, pixel});
    assign thr      = $signed({1'b0, edge_threshold});
    assign neg_thr  = -thr;
    assign col_m1   = count_reg - COUNT_W'(1);

    always_comb
    begin
        rise_val_next = rise_val_reg;
        rise_col_next = rise_col_reg;
        fall_val_next = fall_val_reg;
        fall_col_next = fall_col_reg;
        nz_next       = nz_reg;
        if (watched && in_range)
        begin
            if (count_reg >= COUNT_W'(2))
            begin
                if (diff > rise_val_reg && diff > thr)
                begin
                    rise_val_next = diff;
                    rise_col_next = col_m1[COL_W-1:0];
                end
                if (diff < fall_val_reg && diff < neg_thr)
                begin
                    fall_val_next = diff;
                    fall_col_next = col_m1[COL_W-1:0];
                end
            end
            if (count_reg != '0 && !row_end && pixel == '0)
            begin
                nz_next = 1'b0;
            end
        end
        if (row_end)
        begin
            count_next = '0;
        end
        else if (in_range)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        event_next = event_reg;
        if (take)
        begin
            event_next.valid = 1'b0;
        end
        if (accept && row_end && watched)
        begin
            event_next.valid       = 1'b1;
            event_next.rise_col    = rise_col_next;
            event_next.fall_col    = fall_col_next;
            event_next.all_nonzero = nz_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            count_reg    <= '0;
            rise_val_reg <= '0;
            rise_col_reg <= '0;
            fall_val_reg <= '0;
            fall_col_reg <= '0;
            nz_reg       <= 1'b1;
            event_reg    <= '0;
        end
        else
        begin
            event_reg <= event_next;
            if (accept)
            begin
                prev_reg  <= pixel;
                count_reg <= count_next;
                if (row_end)
                begin
                    rise_val_reg <= '0;
                    rise_col_reg <= '0;
                    fall_val_reg <= '0;
                    fall_col_reg <= '0;
                    nz_reg       <= 1'b1;
                end
                else
                begin
                    rise_val_reg <= rise_val_next;
                    rise_col_reg <= rise_col_next;
                    fall_val_reg <= fall_val_next;
                    fall_col_reg <= fall_col_next;
                    nz_reg       <= nz_next;
                end
            end
        end
    end

    assign event_q = event_reg;

endmodule

### sv/rell_result.sv
module rell_result
    import rell_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rell_event_t             event_q,
    input  logic [COL_W-1:0]        center_column,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OFF_W-1:0] line_offset,
    output logic [COL_W-1:0]        line_width,
    output logic                    line_found,
    output logic                    row_all_nonzero
);

    logic                    valid_reg;
    logic signed [OFF_W-1:0] offset_reg, offset_next;
    logic [COL_W-1:0]        width_reg, width_next;
    logic                    found_reg, found_next;
    logic                    nz_reg;

    logic [OFF_W-1:0]        col_sum;
    logic signed [OFF_W-1:0] col_diff;

    assign take = !valid_reg || !out_stall;

    always_comb
    begin
        found_next = (event_q.rise_col != '0) || (event_q.fall_col != '0);
        col_sum    = {1'b0, event_q.rise_col} + {1'b0, event_q.fall_col};
        col_diff   = $signed({1'b0, event_q.rise_col}) - $signed({1'b0, event_q.fall_col});
        offset_next = $signed({1'b0, col_sum[OFF_W-1:1]}) - $signed({1'b0, center_column});
        if (col_diff < 0)
        begin
            width_next = COL_W'(-col_diff);
        end
        else
        begin
            width_next = col_diff[COL_W-1:0];
        end
        if (!found_next)
        begin
            offset_next = '0;
            width_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= event_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && event_q.valid)
        begin
            offset_reg <= offset_next;
            width_reg  <= width_next;
            found_reg  <= found_next;
            nz_reg     <= event_q.all_nonzero;
        end
    end

    assign out_valid       = valid_reg;
    assign line_offset     = offset_reg;
    assign line_width      = width_reg;
    assign line_found      = found_reg;
    assign row_all_nonzero = nz_reg;

endmodule

### test/tb_row_edge_line_locator.sv
`timescale 1ns / 100ps

module tb_row_edge_line_locator;
    import rell_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int WIDE_ROW_LEN = MAX_COLS + 6;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [ROW_W-1:0] row;
        logic             last;
    } pixel_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [COL_W-1:0] width;
        logic             found;
        logic             nonzero;
    } line_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [PIX_W-1:0]        pixel = '0;
    logic [ROW_W-1:0]        row_index = '0;
    logic                    row_end = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OFF_W-1:0] line_offset;
    logic [COL_W-1:0]        line_width;
    logic                    line_found;
    logic                    row_all_nonzero;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    rell_reg_t               cfg_index = REG_WATCH_ROW;
    logic [31:0]             cfg_data = '0;

    row_edge_line_locator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .row_index       (row_index),
        .row_end         (row_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_offset     (line_offset),
        .line_width      (line_width),
        .line_found      (line_found),
        .row_all_nonzero (row_all_nonzero),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register copies
    logic [ROW_W-1:0] cur_watch_row = '0;
    logic [COL_W-1:0] cur_center = '0;
    logic [THR_W-1:0] cur_threshold = '0;

    // row scan state
    logic [PIX_W-1:0]        prev_px = '0;
    logic [COUNT_W-1:0]      col_count = '0;
    logic [PIX_W-1:0]        rise_step = '0;
    logic [COL_W-1:0]        rise_col = '0;
    logic signed [DIFF_W-1:0] fall_step = '0;
    logic [COL_W-1:0]        fall_col = '0;
    logic                    nonzero_run = 1'b1;

    pixel_item_t  pending_pixels[$];
    line_result_t line_results_due[$];
    line_result_t line_want;
    pixel_item_t  next_pixel;

    int items_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int settings_used = 0;
    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_timer = 0;
    int stall_pct = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic locate_line(input logic [PIX_W-1:0] px, input logic [ROW_W-1:0] row,
                               input logic last);
        logic             watched;
        int               col;
        int               d;
        int               th;
        int               off;
        int               wid;
        logic [COL_W:0]   col_sum;
        line_result_t     res;
        watched = (row == cur_watch_row) && (int'(cur_watch_row) < MAX_ROWS);
        col = int'(col_count);
        if (watched && col < MAX_COLS)
        begin
            if (col >= 2)
            begin
                d = int'(prev_px) - int'(px);
                th = int'(cur_threshold);
                if (d > int'(rise_step) && d > th)
                begin
                    rise_step = d[PIX_W-1:0];
                    rise_col = COL_W'(col - 1);
                end
                if (d < int'(fall_step) && d < -th)
                begin
                    fall_step = d[DIFF_W-1:0];
                    fall_col = COL_W'(col - 1);
                end
            end
            if (col >= 1 && !last && px == '0)
                nonzero_run = 1'b0;
        end
        if (last && watched)
        begin
            res.found = (rise_col != '0) || (fall_col != '0);
            col_sum = {1'b0, rise_col} + {1'b0, fall_col};
            off = int'(col_sum[COL_W:1]) - int'(cur_center);
            wid = int'(rise_col) - int'(fall_col);
            if (wid < 0)
                wid = -wid;
            if (!res.found)
            begin
                off = 0;
                wid = 0;
            end
            res.offset = off[OFF_W-1:0];
            res.width = wid[COL_W-1:0];
            res.nonzero = nonzero_run;
            line_results_due.push_back(res);
        end
        prev_px = px;
        if (last)
        begin
            col_count = '0;
            rise_step = '0;
            rise_col = '0;
            fall_step = '0;
            fall_col = '0;
            nonzero_run = 1'b1;
        end
        else if (int'(col_count) < MAX_COLS)
        begin
            col_count = col_count + 1'b1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        else if (r < 7)
            return $urandom_range(1, 3);
        return $urandom_range(4, 15);
    endfunction

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                locate_line(pixel, row_index, row_end);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_pixel = pending_pixels.pop_front();
                    pixel <= next_pixel.px;
                    row_index <= next_pixel.row;
                    row_end <= next_pixel.last;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result; its stall level changes at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_timer = 0;
            stall_pct = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (line_results_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result offset %0d width %0d found %0b",
                                              line_offset, line_width, line_found));
                end
                else
                begin
                    line_want = line_results_due.pop_front();
                    if (line_offset !== line_want.offset)
                        report_mismatch($sformatf("line_offset %0d, want %0d", line_offset,
                                                  $signed(line_want.offset)));
                    if (line_width !== line_want.width)
                        report_mismatch($sformatf("line_width %0d, want %0d", line_width,
                                                  line_want.width));
                    if (line_found !== line_want.found)
                        report_mismatch($sformatf("line_found %0b, want %0b", line_found,
                                                  line_want.found));
                    if (row_all_nonzero !== line_want.nonzero)
                        report_mismatch($sformatf("row_all_nonzero %0b, want %0b",
                                                  row_all_nonzero, line_want.nonzero));
                    results_checked++;
                end
            end
            if (stall_timer <= 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                stall_timer = $urandom_range(20, 120);
            end
            stall_timer--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("[row_edge_line_locator] ERROR");
        $finish;
    end

    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic [ROW_W-1:0] row,
                              input logic last);
        pixel_item_t it;
        it.px = px;
        it.row = row;
        it.last = last;
        pending_pixels.push_back(it);
        items_queued++;
    endtask

    // pixels packed first-leftmost, one byte each
    task automatic queue_seq(input logic [ROW_W-1:0] row, input int n, input logic [63:0] pix);
        for (int i = 0; i < n; i++)
            push_pixel(pix[8*(n-1-i) +: 8], row, i == n - 1);
    endtask

    task automatic queue_row(input logic [ROW_W-1:0] row, input int len, input int style);
        int bg;
        int fg;
        int a;
        int b;
        int v;
        bg = $urandom_range(0, 255);
        fg = $urandom_range(0, 255);
        a = $urandom_range(1, len);
        b = $urandom_range(a, len);
        for (int i = 0; i < len; i++)
        begin
            v = (i >= a && i < b) ? fg : bg;
            case (style)
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 0;
                        1: v = 255;
                        default: v = $urandom_range(0, 255);
                    endcase
                end
                2:
                begin
                    v = v + $urandom_range(0, 20) - 10;
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                end
                3:
                begin
                    if ($urandom_range(0, 7) == 0)
                        v = 0;
                end
                default: ;
            endcase
            push_pixel(v[PIX_W-1:0], row, i == len - 1);
        end
    endtask

    // watched row running past the column limit; zeros and steps beyond it must be ignored
    task automatic queue_wide_row(input logic [ROW_W-1:0] row);
        int v;
        for (int i = 0; i < WIDE_ROW_LEN; i++)
        begin
            if (i == 1)
                v = 255;
            else if (i == 2)
                v = 1;
            else if (i == MAX_COLS - 2)
                v = 30;
            else if (i == MAX_COLS - 1)
                v = 250;
            else if (i >= MAX_COLS)
                v = (i % 2 == 0) ? 0 : 255;
            else
                v = 100;
            push_pixel(v[PIX_W-1:0], row, i == WIDE_ROW_LEN - 1);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(1, 2);
        else if (r == 1)
            return $urandom_range(50, 120);
        return $urandom_range(3, 24);
    endfunction

    task automatic queue_phase(input int target);
        int start;
        int kind;
        int n;
        start = items_queued;
        while (items_queued - start < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                queue_row(cur_watch_row, pick_len(), $urandom_range(0, 3));
            end
            else if (kind < 8)
            begin
                queue_row(ROW_W'($urandom), pick_len(), $urandom_range(0, 3));
            end
            else if (kind == 8)
            begin
                // watched pixels cut short, row finished under another index
                n = $urandom_range(2, 8);
                for (int i = 0; i < n; i++)
                    push_pixel(PIX_W'($urandom), cur_watch_row, 1'b0);
                queue_row(ROW_W'($urandom), $urandom_range(1, 6), 1);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_pixel(PIX_W'($urandom),
                               ($urandom_range(0, 1) == 1) ? cur_watch_row : ROW_W'($urandom),
                               $urandom_range(0, 5) == 0);
            end
        end
    endtask

    task automatic write_reg(input rell_reg_t idx, input logic [31:0] value);
        logic [31:0] data;
        data = $urandom;
        case (idx)
            REG_WATCH_ROW:     data[ROW_W-1:0] = value[ROW_W-1:0];
            REG_CENTER_COLUMN: data[COL_W-1:0] = value[COL_W-1:0];
            default:           data[THR_W-1:0] = value[THR_W-1:0];
        endcase
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WATCH_ROW:     cur_watch_row = data[ROW_W-1:0];
            REG_CENTER_COLUMN: cur_center = data[COL_W-1:0];
            default:           cur_threshold = data[THR_W-1:0];
        endcase
    endtask

    task automatic write_settings(input int watch, input int centre, input int thr);
        write_reg(REG_WATCH_ROW, watch);
        write_reg(REG_CENTER_COLUMN, centre);
        write_reg(REG_EDGE_THRESHOLD, thr);
        settings_used++;
    endtask

    // hold until every transfer is taken and every result is back
    task automatic wait_idle();
        while (items_taken != items_queued || line_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int watch;
        int centre;
        int thr;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: watch row 0, centre 0, threshold 0
        settings_used++;
        queue_seq(10'd0, 1, 64'hFF);
        queue_seq(10'd0, 2, 64'h0000);
        queue_seq(10'd0, 5, 64'h00FF00FF07);
        queue_seq(10'd5, 3, 64'h102030);
        wait_idle();

        write_settings(1023, 1023, 255);
        queue_seq(10'd1023, 4, 64'h00FF00FF);
        wait_idle();
        write_reg(REG_EDGE_THRESHOLD, 0);
        settings_used++;
        queue_seq(10'd1023, 6, 64'h0A320A320A32);
        queue_seq(10'd1022, 2, 64'h0000);
        wait_idle();

        write_settings($urandom_range(0, 1023), 0, 40);
        queue_wide_row(cur_watch_row);
        queue_phase(10);
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            watch = (p == 0) ? 0 : (p == 1) ? 1023 : $urandom_range(0, 1023);
            centre = (p == 2) ? 0 : (p == 3) ? 1023 : $urandom_range(0, 1023);
            thr = (p == 4) ? 255 : (p == 5) ? 0 : $urandom_range(1, 60);
            write_settings(watch, centre, thr);
            queue_phase(20);
            wait_idle();
            queue_phase(20);
            wait_idle();
        end

        $display("Sent %0d pixel transfers under %0d register settings, including a row past",
                 items_taken, settings_used);
        $display("the column limit; %0d line results checked.", results_checked);
        if (error_count == 0)
            $display("[row_edge_line_locator] OK");
        else
            $display("[row_edge_line_locator] ERROR");
        $finish;
    end

endmodule
